// File: rtl/core/cir_pkg.sv
// Shared sizes, codes and control types for the co-occurrence recommender.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none
package cir_pkg;
    localparam int USERS = 64;
    localparam int ITEMS = 32;
    localparam int LIM = (ITEMS < 32) ? ITEMS : 32;
    localparam int USER_AW = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int USER_CW = $clog2(USERS + 1);
    localparam int CAND_IW = (LIM > 1) ? $clog2(LIM) : 1;
    localparam int CAND_CW = $clog2(LIM + 1);
    localparam int SCORE_W = 11;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [31:0] LIM_MASK = (LIM == 32) ? 32'hFFFF_FFFF : ((32'd1 << LIM) - 32'd1);
    localparam logic [31:0] CATALOG_RESET = 32'd31;

    localparam logic [2:0] ST_REC      = 3'd0;
    localparam logic [2:0] ST_ADDED    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_score_ctl;
endpackage
`default_nettype wire

// File: rtl/core/cir_ifs.sv
// Request, result and configuration channel interfaces (valid/ready).
// Depends on nothing.
`default_nettype none
interface cir_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic signed [31:0] user_id;
    logic [31:0] purchases;
    modport source (output valid, kind, user_id, purchases, input ready);
    modport sink   (input valid, kind, user_id, purchases, output ready);
endinterface

interface cir_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  item_id;
    logic [10:0] score;
    logic        last;
    modport source (output valid, status, item_id, score, last, input ready);
    modport sink   (input valid, status, item_id, score, last, output ready);
endinterface

interface cir_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cooccurrence_item_recommender.sv
// Top level of the co-occurrence recommender: control sequencer, user store, sort.
// Depends on cir_pkg, cir_ifs, cir_ram and cir_score.
`default_nettype none
// Usage
//   i_req carries one request: kind, user_id, purchases. It is taken when
//   valid and ready are high at a rising edge; ready is high only while the
//   block is idle and its result register is empty.
//   o_res carries results; every request produces one or more, the final one
//   flagged by last. A held result waits for o_res.ready; the sequencer
//   stalls in its emit step until the result register is free.
//   i_cfg writes catalog_mask; it is always ready and must only be used idle.
// Sequence
//   An add answers in the next cycle. A query reads the user memory once to find
//   the user, once more to accumulate scores, compacts the 32 score
//   registers, then runs the selection sort one compare a cycle, pausing
//   to emit each result only when the result register is free. The single
//   read port of the user memory and the single comparator of the sort set
//   the pace; a new request is taken only once the last one is answered.
// Reset
//   Clears user count, state and result valid; catalog_mask returns to 31.
//   The user memory is not cleared: entries at or above the count are never read.
module cooccurrence_item_recommender (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cir_req_if.sink   i_req,
    cir_res_if.source o_res,
    cir_cfg_if.sink   i_cfg
);
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_FIND    = 6'b000010,
        S_SCORE   = 6'b000100,
        S_COMPACT = 6'b001000,
        S_SCAN    = 6'b010000,
        S_EMIT    = 6'b100000
    } t_state;

    localparam int AW = cir_pkg::USER_AW;
    localparam int CW = cir_pkg::USER_CW;
    localparam int IW = cir_pkg::CAND_IW;
    localparam int KW = cir_pkg::CAND_CW;

    t_state r_state, n_state;
    logic [31:0] r_catalog;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_addr, n_addr;
    logic r_rv, n_rv;
    logic signed [31:0] r_uid, n_uid;
    logic [31:0] r_self, n_self;

    // result register
    logic r_ov, n_ov;
    logic [2:0] r_ost, n_ost;
    logic [5:0] r_oitem, n_oitem;
    logic [10:0] r_osc, n_osc;
    logic r_olast, n_olast;

    // candidate list and sort
    logic [5:0] r_ritem [cir_pkg::LIM];
    logic [cir_pkg::SCORE_W-1:0] r_rsc [cir_pkg::LIM];
    logic [KW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_c, n_c;
    logic [IW-1:0] r_i, n_i, r_j, n_j, r_best, n_best;
    logic [cir_pkg::SCORE_W-1:0] r_bsc, n_bsc, r_csc, n_csc;
    logic [5:0] r_bitem, n_bitem, r_citem, n_citem;
    logic cand_we, swap_we;

    logic issue;
    logic ram_we;
    logic [63:0] ram_rdata;
    logic id_match;
    cir_pkg::t_score_ctl score_ctl;
    logic [cir_pkg::SCORE_W-1:0] rd_score;
    logic score_busy;
    logic in_fire, out_fire, j_last, i_last;

    assign in_fire  = i_req.valid && i_req.ready;
    assign out_fire = r_ov && o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_ov;
    assign i_cfg.ready = 1'b1;

    assign issue = ((r_state == S_FIND) || (r_state == S_SCORE)) && (r_addr < r_count);
    assign ram_we = in_fire && (i_req.kind == cir_pkg::KIND_ADD)
                 && (r_count < CW'(cir_pkg::USERS));
    assign id_match = r_rv && (ram_rdata[63:32] == r_uid);
    assign j_last = ((KW'(r_j) + KW'(1)) == r_cnt);
    assign i_last = ((KW'(r_i) + KW'(1)) == r_cnt);

    cir_ram #(.WIDTH(64), .DEPTH(cir_pkg::USERS)) u_users (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_req.user_id, i_req.purchases & r_catalog}),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    cir_score u_score (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (score_ctl),
        .i_items    (ram_rdata[31:0]),
        .i_self     (r_self),
        .i_catalog  (r_catalog),
        .i_rd_idx   (r_c),
        .o_rd_score (rd_score),
        .o_busy     (score_busy)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_addr  = issue ? r_addr + CW'(1) : r_addr;
        n_rv    = issue;
        n_uid   = r_uid;
        n_self  = r_self;
        n_ov    = out_fire ? 1'b0 : r_ov;
        n_ost   = r_ost;
        n_oitem = r_oitem;
        n_osc   = r_osc;
        n_olast = r_olast;
        n_cnt   = r_cnt;
        n_c     = r_c;
        n_i     = r_i;
        n_j     = r_j;
        n_best  = r_best;
        n_bsc   = r_bsc;
        n_bitem = r_bitem;
        n_csc   = r_csc;
        n_citem = r_citem;
        cand_we = 1'b0;
        swap_we = 1'b0;
        score_ctl.clear = 1'b0;
        score_ctl.valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_addr = '0;
                n_rv   = 1'b0;
                if (in_fire) begin
                    n_uid = i_req.user_id;
                    if (i_req.kind == cir_pkg::KIND_ADD) begin
                        // answer at once: added or store full
                        n_ov    = 1'b1;
                        n_oitem = '0;
                        n_osc   = '0;
                        n_olast = 1'b1;
                        if (ram_we) begin
                            n_ost   = cir_pkg::ST_ADDED;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_ost = cir_pkg::ST_FULL;
                        end
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (id_match) begin
                    n_self  = ram_rdata[31:0];
                    n_addr  = '0;
                    n_rv    = 1'b0;
                    score_ctl.clear = 1'b1;
                    n_state = S_SCORE;
                end else if (r_addr >= r_count) begin
                    n_ov    = 1'b1;
                    n_ost   = cir_pkg::ST_NOTFOUND;
                    n_oitem = '0;
                    n_osc   = '0;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCORE: begin
                score_ctl.valid = r_rv;
                if (!issue && !r_rv && !score_busy) begin
                    n_c     = '0;
                    n_cnt   = '0;
                    n_state = S_COMPACT;
                end
            end
            S_COMPACT: begin
                // append nonzero scores in item order
                if (rd_score != '0) begin
                    cand_we = 1'b1;
                    n_cnt   = r_cnt + KW'(1);
                end
                if (32'(r_c) == 32'(cir_pkg::LIM - 1)) begin
                    n_i = '0;
                    n_j = '0;
                    if (n_cnt == '0) begin
                        n_ov    = 1'b1;
                        n_ost   = cir_pkg::ST_NONE;
                        n_oitem = '0;
                        n_osc   = '0;
                        n_olast = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else begin
                    n_c = r_c + IW'(1);
                end
            end
            S_SCAN: begin
                if (r_j == r_i) begin
                    n_best  = r_j;
                    n_bsc   = r_rsc[r_j];
                    n_bitem = r_ritem[r_j];
                    n_csc   = r_rsc[r_j];
                    n_citem = r_ritem[r_j];
                end else if (r_rsc[r_j] > r_bsc) begin
                    n_best  = r_j;
                    n_bsc   = r_rsc[r_j];
                    n_bitem = r_ritem[r_j];
                end
                if (j_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            S_EMIT: begin
                // position i is final: send it, move the displaced entry to best
                if (!r_ov) begin
                    swap_we = (r_best != r_i);
                    n_ov    = 1'b1;
                    n_ost   = cir_pkg::ST_REC;
                    n_oitem = r_bitem;
                    n_osc   = r_bsc;
                    n_olast = i_last;
                    if (i_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_j     = r_i + IW'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_catalog <= cir_pkg::CATALOG_RESET;
            r_count   <= '0;
            r_addr    <= '0;
            r_rv      <= 1'b0;
            r_ov      <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_catalog <= i_cfg.data;
            end
            r_count <= n_count;
            r_addr  <= n_addr;
            r_rv    <= n_rv;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_uid   <= n_uid;
        r_self  <= n_self;
        r_ost   <= n_ost;
        r_oitem <= n_oitem;
        r_osc   <= n_osc;
        r_olast <= n_olast;
        r_c     <= n_c;
        r_i     <= n_i;
        r_j     <= n_j;
        r_best  <= n_best;
        r_bsc   <= n_bsc;
        r_bitem <= n_bitem;
        r_csc   <= n_csc;
        r_citem <= n_citem;
        if (cand_we) begin
            r_ritem[r_cnt[IW-1:0]] <= 6'(r_c) + 6'd1;
            r_rsc[r_cnt[IW-1:0]]   <= rd_score;
        end else if (swap_we) begin
            r_ritem[r_best] <= r_citem;
            r_rsc[r_best]   <= r_csc;
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.status  = r_ost;
    assign o_res.item_id = r_oitem;
    assign o_res.score   = r_osc;
    assign o_res.last    = r_olast;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE))
        else $error("request taken while busy");
    a_rec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_ost == cir_pkg::ST_REC)) |-> (r_osc != '0) && (r_oitem != '0))
        else $error("recommendation with zero score or item");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(cir_pkg::USERS)) && (r_cnt <= KW'(cir_pkg::LIM)))
        else $error("count out of range");
    a_add_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_req.kind == cir_pkg::KIND_ADD)) |=> (r_ov && r_olast))
        else $error("add produced no result");
endmodule
`default_nettype wire

// File: rtl/core/cir_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module cir_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/cir_score.sv
// Co-occurrence score accumulators, one per catalog item, fed one stored user a cycle.
// Depends on cir_pkg.
`default_nettype none
module cir_score (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire cir_pkg::t_score_ctl        i_ctl,
    input  wire logic [31:0]                i_items,
    input  wire logic [31:0]                i_self,
    input  wire logic [31:0]                i_catalog,
    input  wire logic [cir_pkg::CAND_IW-1:0] i_rd_idx,
    output logic [cir_pkg::SCORE_W-1:0]     o_rd_score,
    output logic                            o_busy
);
    logic                        r_pv;
    logic [5:0]                  r_pc;
    logic [31:0]                 r_hit;
    logic [cir_pkg::SCORE_W-1:0] r_sc [cir_pkg::LIM];
    logic [31:0]                 n_hit;

    // candidate items this user bought: in catalog, in scan range, not owned by self
    assign n_hit = i_items & i_catalog & ~i_self & cir_pkg::LIM_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.valid && !i_ctl.clear;
        end
        r_pc  <= 6'($countones(i_items & i_self & cir_pkg::LIM_MASK));
        r_hit <= n_hit;
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < cir_pkg::LIM; c++) begin
            logic [cir_pkg::SCORE_W:0] sum;
            sum = {1'b0, r_sc[c]} + (cir_pkg::SCORE_W + 1)'(r_pc);
            if (i_ctl.clear) begin
                r_sc[c] <= '0;
            end else if (r_pv && r_hit[c]) begin
                r_sc[c] <= sum[cir_pkg::SCORE_W] ? cir_pkg::SCORE_MAX
                                                 : sum[cir_pkg::SCORE_W-1:0];
            end
        end
    end

    assign o_rd_score = r_sc[i_rd_idx];
    assign o_busy     = r_pv;
endmodule
`default_nettype wire

// File: verif/cir_tb_ifs.sv
// Testbench-side note: the channel interfaces come from rtl/core/cir_ifs.sv.
// This file holds the scoreboard types shared by the testbench top; depends on nothing.
package cir_tb_pkg;
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  item_id;
        logic [10:0] score;
        logic        last;
    } t_rec_result;
endpackage

// File: verif/tb.sv
// Self-checking testbench for cooccurrence_item_recommender: directed and random
// add/query requests, catalog changes while idle, random idling on both channels.
// Depends on cir_pkg, cir_ifs (RTL) and cir_tb_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the block's user store and catalog; predicts results per request.
    class recommend_board;
        logic [31:0] catalog;
        logic [31:0] ids[cir_pkg::USERS];
        logic [31:0] bought[cir_pkg::USERS];
        int          stored;
        cir_tb_pkg::t_rec_result pending[$];
        int          errors;

        function void clear_store();
            catalog = cir_pkg::CATALOG_RESET;
            stored  = 0;
        endfunction

        function void push(logic [2:0] st, logic [5:0] it, logic [10:0] sc, logic lst);
            cir_tb_pkg::t_rec_result r;
            r.status = st; r.item_id = it; r.score = sc; r.last = lst;
            pending.push_back(r);
        endfunction

        // Note one accepted request and queue every result it must cause.
        function void note_request(logic kind, logic [31:0] uid, logic [31:0] pur);
            logic [31:0] self;
            bit          found;
            int          cand_item[32];
            int          cand_score[32];
            int          n, sc, cnt, best, t;
            found = 0;
            n = 0;
            self = '0;
            if (kind == cir_pkg::KIND_ADD) begin
                if (stored >= cir_pkg::USERS) begin
                    push(cir_pkg::ST_FULL, '0, '0, 1'b1);
                end else begin
                    ids[stored] = uid;
                    bought[stored] = pur & catalog;
                    stored++;
                    push(cir_pkg::ST_ADDED, '0, '0, 1'b1);
                end
                return;
            end
            // Earliest stored user with a matching id wins.
            for (int i = 0; i < stored; i++) begin
                if (!found && ids[i] == uid) begin
                    self = bought[i];
                    found = 1;
                end
            end
            if (!found) begin
                push(cir_pkg::ST_NOTFOUND, '0, '0, 1'b1);
                return;
            end
            for (int c = 0; c < cir_pkg::LIM; c++) begin
                if (!catalog[c] || self[c]) continue;
                sc = 0;
                for (int b = 0; b < cir_pkg::LIM; b++) begin
                    if (!self[b]) continue;
                    cnt = 0;
                    for (int u = 0; u < stored; u++)
                        if (bought[u][c] && bought[u][b]) cnt++;
                    sc += cnt;
                    if (sc > 2047) sc = 2047;
                end
                if (sc > 0) begin
                    cand_item[n] = c + 1;
                    cand_score[n] = sc;
                    n++;
                end
            end
            if (n == 0) begin
                push(cir_pkg::ST_NONE, '0, '0, 1'b1);
                return;
            end
            // Selection sort from the front: first strictly greatest, then swap.
            for (int i = 0; i + 1 < n; i++) begin
                best = i;
                for (int j = i + 1; j < n; j++)
                    if (cand_score[j] > cand_score[best]) best = j;
                t = cand_score[i]; cand_score[i] = cand_score[best]; cand_score[best] = t;
                t = cand_item[i]; cand_item[i] = cand_item[best]; cand_item[best] = t;
            end
            for (int i = 0; i < n; i++)
                push(cir_pkg::ST_REC, 6'(cand_item[i]), 11'(cand_score[i]), i == n - 1);
        endfunction

        function void check_result(cir_tb_pkg::t_rec_result got);
            cir_tb_pkg::t_rec_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result st=%0d item=%0d score=%0d last=%0d",
                         $time, got.status, got.item_id, got.score, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            if (got.item_id !== want.item_id)
                $display("%0t: item_id expected %0d actual %0d", $time, want.item_id,
                         got.item_id);
            if (got.score !== want.score)
                $display("%0t: score expected %0d actual %0d", $time, want.score, got.score);
            if (got.last !== want.last)
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            if (got !== want) errors++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    cir_req_if req_ch ();
    cir_res_if res_ch ();
    cir_cfg_if cfg_ch ();

    cooccurrence_item_recommender DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    recommend_board board = new();
    bit  calm;              // no idling on either side while set
    int  cycles = 0;
    localparam int CYCLE_LIMIT = 3_000_000;
    logic [31:0] ids_seen[$];

    // Count cycles and stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: sample at the edge, then pick next ready with random stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_result({res_ch.status, res_ch.item_id, res_ch.score, res_ch.last});
        res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
    end

    // Present one request, hold it until accepted, and note it in the board.
    task automatic send_request(logic kind, logic [31:0] uid, logic [31:0] pur);
        while (!calm && $urandom_range(99) < 12) @(posedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.user_id <= uid;
        req_ch.purchases <= pur;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(kind, uid, pur);
        req_ch.valid <= 1'b0;
        if (kind == cir_pkg::KIND_ADD) ids_seen.push_back(uid);
        // the block is busy for at least this cycle after a request
        @(posedge i_clk);
    endtask

    // Wait for the block to drain, then write the catalog mask.
    task automatic write_catalog(logic [31:0] mask);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= mask;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.catalog = mask;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Random purchases: mostly a few items in the low range so scores overlap.
    function automatic logic [31:0] rand_purchases();
        logic [31:0] p;
        p = '0;
        case ($urandom_range(3))
            0: p = $urandom();
            default: repeat ($urandom_range(1, 5)) p[$urandom_range(0, 9)] = 1'b1;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] pick_id();
        if (ids_seen.size() != 0 && $urandom_range(9) < 8)
            return ids_seen[$urandom_range(ids_seen.size() - 1)];
        return $urandom();
    endfunction

    initial begin
        req_ch.valid = 1'b0;
        req_ch.kind = cir_pkg::KIND_ADD;
        req_ch.user_id = '0;
        req_ch.purchases = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        board.clear_store();
        board.errors = 0;
        calm = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-store query, extremes of id and purchases, duplicates.
        send_request(cir_pkg::KIND_QUERY, 32'd5, '0);
        send_request(cir_pkg::KIND_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(cir_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h0000_0003);
        send_request(cir_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'h0000_0006);
        send_request(cir_pkg::KIND_ADD, 32'd0, 32'h0000_0000);
        send_request(cir_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h0000_0010);   // duplicate id
        send_request(cir_pkg::KIND_QUERY, 32'h7FFF_FFFF, '0);            // earliest copy wins
        send_request(cir_pkg::KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(cir_pkg::KIND_QUERY, 32'h8000_0000, '0);            // bought all: none
        send_request(cir_pkg::KIND_QUERY, 32'd0, '0);                    // empty basket: none
        send_request(cir_pkg::KIND_QUERY, 32'd12345, '0);                // not found

        // Catalog widened to every item, then narrowed: stored bits stay put.
        write_catalog(32'hFFFF_FFFF);
        send_request(cir_pkg::KIND_ADD, 32'd77, 32'hF000_0001);
        send_request(cir_pkg::KIND_ADD, 32'd78, 32'hF000_0002);
        send_request(cir_pkg::KIND_QUERY, 32'd77, '0);
        write_catalog(32'h0000_0000);
        send_request(cir_pkg::KIND_QUERY, 32'd77, '0);
        send_request(cir_pkg::KIND_ADD, 32'd79, 32'hFFFF_FFFF);
        write_catalog(32'h0000_03FF);

        // Random: fill toward the full store with query-heavy traffic.
        for (int n = 0; n < 150; n++) begin
            calm = (n >= 50 && n < 80);
            if (n == 100) write_catalog($urandom());
            if (n == 125) write_catalog(32'h0000_03FF);
            if ($urandom_range(99) < 45)
                send_request(cir_pkg::KIND_ADD,
                             $urandom_range(9) < 3 ? pick_id() : $urandom(),
                             rand_purchases());
            else
                send_request(cir_pkg::KIND_QUERY, pick_id(), $urandom());
        end
        // Past full store: adds are dropped.
        calm = 1'b0;
        while (board.stored < cir_pkg::USERS)
            send_request(cir_pkg::KIND_ADD, $urandom(), rand_purchases());
        send_request(cir_pkg::KIND_ADD, 32'd1, 32'd1);
        send_request(cir_pkg::KIND_QUERY, pick_id(), '0);

        drain();
        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// File: cooccurrence_item_recommender.f
rtl/core/cir_pkg.sv
rtl/core/cir_ifs.sv
rtl/core/cir_ram.sv
rtl/core/cir_score.sv
rtl/core/cooccurrence_item_recommender.sv
verif/cir_tb_ifs.sv
verif/tb.sv
